// ----- src/pid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared definitions of the prefixed instruction decoder
// Function codes, configuration register indexes, the defined-operation
// span table and the configuration write bundle.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int ADDR_BITS         = 32;
    localparam int CFG_DATA_BITS     = 32;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [3:0] FN_J    = 4'h0;
    localparam logic [3:0] FN_PFIX = 4'h2;
    localparam logic [3:0] FN_NFIX = 4'h6;
    localparam logic [3:0] FN_CALL = 4'h9;
    localparam logic [3:0] FN_CJ   = 4'hA;
    localparam logic [3:0] FN_OPR  = 4'hF;

    localparam logic [CFG_INDEX_BITS-1:0] REG_START_ADDRESS    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELATIVE_TARGETS = 1'b1;

    localparam int OPR_LOWEST  = -48;
    localparam int OPR_HIGHEST = 380;
    // Offsets of operation codes from OPR_LOWEST fit in this many bits.
    localparam int OPR_OFFSET_BITS = 9;

    localparam int NUM_SPANS = 22;
    localparam int OP_SPAN_LO [NUM_SPANS] = '{
        -48, -40, -31, -16, -9, 0, 18, 21, 99, 108, 113,
        128, 154, 163, 166, 168, 170, 176, 199, 207, 248, 380
    };
    localparam int OP_SPAN_HI [NUM_SPANS] = '{
        -45, -35, -18, -11, -3, 16, 19, 95, 99, 109, 126,
        152, 161, 164, 166, 168, 172, 197, 204, 223, 251, 380
    };

    typedef struct packed {
        logic                      write;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_write_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // True when the code at the given offset above OPR_LOWEST is defined.
    function automatic logic op_defined(input logic [OPR_OFFSET_BITS-1:0] offset);
        int   code;
        logic hit;
        code = int'(offset) + OPR_LOWEST;
        hit  = 1'b0;
        for (int i = 0; i < NUM_SPANS; i++)
        begin
            if (code >= OP_SPAN_LO[i] && code <= OP_SPAN_HI[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- src/pid_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_front: byte intake and prefix accumulation
// Accepts instruction bytes, builds the operand from prefixes, tracks the
// byte address and queues each completed instruction.
// ----------------------------------------------------------------------------
module pid_front #(
    parameter int WORD_BITS = pid_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            code_byte,
    input  pid_pkg::cfg_write_t                   cfg,
    input  pid_pkg::queue_status_t                queue_status,
    output logic                                  push,
    output logic [4+WORD_BITS+pid_pkg::ADDR_BITS-1:0] push_data
);

    logic [WORD_BITS-1:0]          operand_reg, operand_next;
    logic [pid_pkg::ADDR_BITS-1:0] address_reg, address_next;
    logic [3:0]                    fn;
    logic [3:0]                    nibble;
    logic [WORD_BITS-1:0]          ored;
    logic [WORD_BITS-1:0]          shifted;
    logic                          accept;
    logic                          complete;
    logic [WORD_BITS-1:0]          emit_operand;

    assign in_stall = queue_status.full;
    assign accept   = in_valid && !in_stall;
    assign fn       = code_byte[7:4];
    assign nibble   = code_byte[3:0];
    assign ored     = operand_reg | {{(WORD_BITS-4){1'b0}}, nibble};
    assign shifted  = ored << 4;

    always_comb
    begin
        operand_next = operand_reg;
        complete     = 1'b0;
        emit_operand = ored;
        case (fn)
            pid_pkg::FN_NFIX:
            begin
                operand_next = (~ored) << 4;
            end
            pid_pkg::FN_PFIX:
            begin
                operand_next = shifted;
                // A zero prefix that leaves the register at zero stands alone.
                complete     = (nibble == 4'h0) && (shifted == '0);
                emit_operand = '0;
            end
            default:
            begin
                operand_next = '0;
                complete     = 1'b1;
            end
        endcase
    end

    assign push      = accept && complete;
    assign push_data = {fn, emit_operand, address_reg};

    always_comb
    begin
        address_next = address_reg;
        if (cfg.write && cfg.index == pid_pkg::REG_START_ADDRESS)
        begin
            address_next = cfg.data;
        end
        else if (accept)
        begin
            address_next = address_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_reg <= '0;
            address_reg <= '0;
        end
        else
        begin
            address_reg <= address_next;
            if (accept)
            begin
                operand_reg <= operand_next;
            end
        end
    end

endmodule

// ----- src/pid_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_queue: short queue between intake and execution
// A small register queue of completed instructions with full and empty flags.
// ----------------------------------------------------------------------------
module pid_queue #(
    parameter int DEPTH = pid_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output pid_pkg::queue_status_t status
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign status.full  = (count_reg == COUNT_BITS'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("pid_queue: item pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("pid_queue: item popped from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("pid_queue: count did not follow a push");
`endif

endmodule

// ----- src/pid_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_back: instruction execution and result register
// Takes completed instructions from the queue, works out the branch target
// and the operation check, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pid_back #(
    parameter int WORD_BITS = pid_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  pid_pkg::cfg_write_t                       cfg,
    input  pid_pkg::queue_status_t                    queue_status,
    input  logic [4+WORD_BITS+pid_pkg::ADDR_BITS-1:0] pop_data,
    output logic                                      pop,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [3:0]                                function_code,
    output logic signed [31:0]                        operand,
    output logic [31:0]                               last_byte_address,
    output logic [31:0]                               branch_target,
    output logic                                      target_valid,
    output logic                                      operation_known
);

    localparam int EXT_BITS = (WORD_BITS > 32) ? WORD_BITS : 32;

    logic                          out_valid_reg, out_valid_next;
    logic                          relative_reg;
    logic [3:0]                    fn;
    logic [WORD_BITS-1:0]          raw_operand;
    logic [pid_pkg::ADDR_BITS-1:0] addr;
    logic signed [EXT_BITS-1:0]    op_ext;
    logic [31:0]                   op32;
    logic                          is_branch;
    logic                          tgt_valid;
    logic                          in_range;
    logic [pid_pkg::OPR_OFFSET_BITS-1:0] op_offset;
    logic                          known;

    logic [3:0]  fn_reg;
    logic [31:0] operand_reg;
    logic [31:0] address_reg;
    logic [31:0] target_reg;
    logic        target_valid_reg;
    logic        known_reg;

    assign {fn, raw_operand, addr} = pop_data;

    assign op_ext = EXT_BITS'(signed'(raw_operand));
    assign op32   = op_ext[31:0];

    assign is_branch = (fn == pid_pkg::FN_J) || (fn == pid_pkg::FN_CJ)
                    || (fn == pid_pkg::FN_CALL);
    assign tgt_valid = is_branch && relative_reg;

    assign in_range  = (op_ext >= pid_pkg::OPR_LOWEST) && (op_ext <= pid_pkg::OPR_HIGHEST);
    // The offset stays below 2^9 inside the range, so the low bits suffice.
    assign op_offset = op_ext[pid_pkg::OPR_OFFSET_BITS-1:0]
                     - pid_pkg::OPR_OFFSET_BITS'(pid_pkg::OPR_LOWEST);
    assign known     = (fn == pid_pkg::FN_OPR) && in_range && pid_pkg::op_defined(op_offset);

    assign pop = !queue_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            relative_reg  <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.write)
            begin
                case (cfg.index)
                    pid_pkg::REG_RELATIVE_TARGETS: relative_reg <= cfg.data[0];
                    default:                       relative_reg <= relative_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fn_reg           <= fn;
            operand_reg      <= op32;
            address_reg      <= addr;
            target_reg       <= tgt_valid ? (addr + op32 + 32'd1) : 32'd0;
            target_valid_reg <= tgt_valid;
            known_reg        <= known;
        end
    end

    assign out_valid         = out_valid_reg;
    assign function_code     = fn_reg;
    assign operand           = signed'(operand_reg);
    assign last_byte_address = address_reg;
    assign branch_target     = target_reg;
    assign target_valid      = target_valid_reg;
    assign operation_known   = known_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && target_valid_reg) |->
        (fn_reg == pid_pkg::FN_J || fn_reg == pid_pkg::FN_CJ || fn_reg == pid_pkg::FN_CALL))
        else $error("pid_back: target reported for a function that is not a branch");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && known_reg) |-> (fn_reg == pid_pkg::FN_OPR))
        else $error("pid_back: operation check reported for a function other than opr");
`endif

endmodule

// ----- src/prefixed_instruction_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_instruction_decoder: prefix-coded instruction stream decoder
// Folds prefix bytes into operands and reports each completed instruction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one instruction byte per item on code_byte, with
// in_valid and in_stall. Prefix and negative prefix bytes only build up the
// operand; every other byte, and a zero prefix that leaves the operand at
// zero, completes an instruction and yields one result item on the output
// channel (out_valid, out_stall).
// Throughput is one byte per cycle while in_stall is low. The accepting edge
// of the byte that completes a result writes it into the queue, and the
// result register loads it from there when the output is not stalled.
// A four-entry queue separates intake from execution. When the receiver
// stalls, results back up into the queue and in_stall rises once it is full.
// Reset clears the operand, sets the byte address to zero, enables relative
// targets, empties the queue. Writing start_address reloads the byte address.
// The user must write configuration only while the block is idle; unenforced.
// ----------------------------------------------------------------------------
module prefixed_instruction_decoder #(
    parameter int WORD_BITS = pid_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pid_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pid_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           code_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           function_code,
    output logic signed [31:0]                   operand,
    output logic [31:0]                          last_byte_address,
    output logic [31:0]                          branch_target,
    output logic                                 target_valid,
    output logic                                 operation_known
);

    localparam int ENTRY_BITS = 4 + WORD_BITS + pid_pkg::ADDR_BITS;

    pid_pkg::cfg_write_t    cfg;
    pid_pkg::queue_status_t queue_status;
    logic                   push;
    logic                   pop;
    logic [ENTRY_BITS-1:0]  push_data;
    logic [ENTRY_BITS-1:0]  pop_data;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    pid_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_byte    (code_byte),
        .cfg          (cfg),
        .queue_status (queue_status),
        .push         (push),
        .push_data    (push_data)
    );

    pid_queue #(
        .DEPTH (pid_pkg::QUEUE_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (queue_status)
    );

    pid_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .queue_status      (queue_status),
        .pop_data          (pop_data),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .function_code     (function_code),
        .operand           (operand),
        .last_byte_address (last_byte_address),
        .branch_target     (branch_target),
        .target_valid      (target_valid),
        .operation_known   (operation_known)
    );

endmodule
